// File: sv/wpm_pkg.sv
// Shared constants and types for the 3x3 binary window pattern matcher.
`default_nettype none

package wpm_pkg;

    localparam int MAX_WIDTH    = 2048;
    localparam int MAX_HEIGHT   = 2048;
    localparam int MIN_DIM      = 3;

    localparam int PIXEL_W      = 32;
    localparam int DIM_W        = 12;
    localparam int PATTERN_W    = 9;
    localparam int CENTER_W     = 11;
    localparam int CFG_DATA_W   = 32;
    localparam int CFG_INDEX_W  = 2;

    localparam int COL_W        = $clog2(MAX_WIDTH);
    localparam int ROW_W        = $clog2(MAX_HEIGHT);
    localparam int COL_WIDE_W   = (COL_W + 1 > DIM_W) ? COL_W + 1 : DIM_W;
    localparam int ROW_WIDE_W   = (ROW_W + 1 > DIM_W) ? ROW_W + 1 : DIM_W;

    // one cell holds one window column: {bottom, middle, top}
    localparam int COLUMN_H     = 3;
    localparam int NUM_CELLS    = 3;

    // line store word: {two rows above, row above}
    localparam int LINE_WORD_W  = 2;

    localparam logic [DIM_W-1:0]      WIDTH_RESET      = DIM_W'(640);
    localparam logic [DIM_W-1:0]      HEIGHT_RESET     = DIM_W'(480);
    localparam logic [PIXEL_W-1:0]    BACKGROUND_RESET = 32'hffff_ffff;
    localparam logic [PATTERN_W-1:0]  PATTERN_RESET    = 9'h1ff;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1,
        REG_BACKGROUND   = 2'd2,
        REG_PATTERN      = 2'd3
    } cfg_index_t;

    typedef logic [COLUMN_H-1:0] column_t;

    typedef struct packed {
        logic hit;
        logic active;
    } cell_flags_t;

    typedef struct packed {
        logic [CENTER_W-1:0] center_x;
        logic [CENTER_W-1:0] center_y;
    } result_t;

endpackage

`default_nettype wire

// File: sv/wpm_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module wpm_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 2048
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: sv/wpm_cell.sv
// One window column cell: holds a 3-bit column, passes it to its left neighbour.
`default_nettype none

module wpm_cell
    import wpm_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    shift,
    input  wire column_t col_in,
    input  wire column_t pat_col,
    output column_t      col_out,
    output cell_flags_t  flags
);

    column_t col_reg;
    column_t col_next;

    assign col_next = shift ? col_in : col_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
        end
    end

    assign col_out = col_reg;

    // flags describe the column as it stands after this shift
    assign flags.hit    = (col_in == pat_col);
    assign flags.active = |col_in;

endmodule

`default_nettype wire

// File: sv/wpm_queue.sv
// Two-word result queue between the window stage and the output port.
`default_nettype none

module wpm_queue
    import wpm_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    input  wire result_t push_data,
    input  wire logic    pop_ready,
    output logic         head_valid,
    output result_t      head_data,
    output logic         pop,
    output logic [1:0]   count
);

    result_t    entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign head_valid = (count_reg != 2'd0);
    assign head_data  = entry_reg[rd_ptr_reg];
    assign pop        = head_valid && pop_ready;
    assign count      = count_reg;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// File: sv/window_pattern_match_3x3_top.sv
// Top level of the 3x3 binary window pattern matcher.
`default_nettype none

// Takes one 32-bit pixel per clock when pixel_ready is high, in raster order,
// and reports the centre of every interior 3x3 window whose active/inactive
// map (active = differs from the background colour) equals the programmed
// 9-bit pattern; an all-inactive window never matches. A pixel is read against
// the two-row line store in the cycle it is taken and is windowed in the next,
// where a match enters the result queue; the line store's single read and
// write ports allow one pixel every cycle while pixel_ready is high. A two-word
// result queue lets pixels keep flowing while a result waits to be taken.
// After reset the line store is cleared one entry per cycle, MAX_WIDTH in all,
// during which pixel_ready stays low; configuration writes are taken at any
// time but should only be issued while the block is idle.
module window_pattern_match_3x3_top
    import wpm_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_write,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                   pixel_valid,
    output logic                        pixel_ready,
    input  wire logic [PIXEL_W-1:0]     pixel,
    output logic                        match_valid,
    input  wire logic                   match_ready,
    output logic      [CENTER_W-1:0]    center_x,
    output logic      [CENTER_W-1:0]    center_y
);

    // configuration
    logic [DIM_W-1:0]     image_width_reg;
    logic [DIM_W-1:0]     image_height_reg;
    logic [PIXEL_W-1:0]   background_reg;
    logic [PATTERN_W-1:0] pattern_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= WIDTH_RESET;
            image_height_reg <= HEIGHT_RESET;
            background_reg   <= BACKGROUND_RESET;
            pattern_reg      <= PATTERN_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index_t'(cfg_index))
                REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[DIM_W-1:0];
                REG_IMAGE_HEIGHT: image_height_reg <= cfg_data[DIM_W-1:0];
                REG_BACKGROUND:   background_reg   <= cfg_data[PIXEL_W-1:0];
                REG_PATTERN:      pattern_reg      <= cfg_data[PATTERN_W-1:0];
                default:          ;
            endcase
        end
    end

    // clamped frame size
    logic [COL_WIDE_W-1:0] width_eff;
    logic [ROW_WIDE_W-1:0] height_eff;

    always_comb
    begin
        if (COL_WIDE_W'(image_width_reg) < COL_WIDE_W'(MIN_DIM))
        begin
            width_eff = COL_WIDE_W'(MIN_DIM);
        end
        else if (COL_WIDE_W'(image_width_reg) > COL_WIDE_W'(MAX_WIDTH))
        begin
            width_eff = COL_WIDE_W'(MAX_WIDTH);
        end
        else
        begin
            width_eff = COL_WIDE_W'(image_width_reg);
        end

        if (ROW_WIDE_W'(image_height_reg) < ROW_WIDE_W'(MIN_DIM))
        begin
            height_eff = ROW_WIDE_W'(MIN_DIM);
        end
        else if (ROW_WIDE_W'(image_height_reg) > ROW_WIDE_W'(MAX_HEIGHT))
        begin
            height_eff = ROW_WIDE_W'(MAX_HEIGHT);
        end
        else
        begin
            height_eff = ROW_WIDE_W'(image_height_reg);
        end
    end

    // line store clearing after reset
    logic [COL_W:0] clr_cnt_reg;
    logic [COL_W:0] clr_cnt_next;
    logic           clearing;

    assign clearing     = (clr_cnt_reg < (COL_W + 1)'(MAX_WIDTH));
    assign clr_cnt_next = clearing ? clr_cnt_reg + 1'b1 : clr_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else
        begin
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    // handshake and raster position
    logic       accept;
    logic       s1_valid_reg;
    logic       q_push;
    logic       q_pop;
    logic [1:0] q_count;
    logic       room;

    // the queue may hold at most two words, counting the one still in flight
    always_comb
    begin
        case (q_count)
            2'd0:    room = 1'b1;
            2'd1:    room = !s1_valid_reg || q_pop;
            2'd2:    room = !s1_valid_reg && q_pop;
            default: room = 1'b0;
        endcase
    end

    assign pixel_ready = !clearing && room;
    assign accept      = pixel_valid && pixel_ready;

    logic [COL_W-1:0]      col_reg;
    logic [COL_W-1:0]      col_next;
    logic [ROW_W-1:0]      row_reg;
    logic [ROW_W-1:0]      row_next;
    logic [COL_W-1:0]      x_cur;
    logic [ROW_W-1:0]      y_cur;
    logic [COL_WIDE_W-1:0] x_inc;
    logic [ROW_WIDE_W-1:0] y_inc;

    always_comb
    begin
        x_cur = (COL_WIDE_W'(col_reg) >= width_eff)  ? '0 : col_reg;
        y_cur = (ROW_WIDE_W'(row_reg) >= height_eff) ? '0 : row_reg;
        x_inc = COL_WIDE_W'(x_cur) + 1'b1;
        y_inc = ROW_WIDE_W'(y_cur) + 1'b1;
        if (x_inc >= width_eff)
        begin
            col_next = '0;
            row_next = (y_inc >= height_eff) ? '0 : y_inc[ROW_W-1:0];
        end
        else
        begin
            col_next = x_inc[COL_W-1:0];
            row_next = y_cur;
        end
    end

    logic             s1_bot_reg;
    logic [COL_W-1:0] s1_x_reg;
    logic [ROW_W-1:0] s1_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            if (accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_bot_reg <= (pixel != background_reg);
            s1_x_reg   <= x_cur;
            s1_y_reg   <= y_cur;
        end
    end

    // line store: {two rows above, row above} per column
    logic                   ram_we;
    logic [COL_W-1:0]       ram_waddr;
    logic [LINE_WORD_W-1:0] ram_wdata;
    logic [LINE_WORD_W-1:0] ram_rdata;

    assign ram_we    = clearing || s1_valid_reg;
    assign ram_waddr = clearing ? clr_cnt_reg[COL_W-1:0] : s1_x_reg;
    assign ram_wdata = clearing ? '0 : {ram_rdata[0], s1_bot_reg};

    wpm_ram #(
        .WIDTH (LINE_WORD_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (x_cur),
        .rdata (ram_rdata)
    );

    // window: newest column enters the rightmost cell and moves left
    column_t     cell_in    [NUM_CELLS];
    column_t     cell_out   [NUM_CELLS];
    column_t     cell_pat   [NUM_CELLS];
    cell_flags_t cell_flags [NUM_CELLS];

    genvar c;
    generate
        for (c = 0; c < NUM_CELLS; c++)
        begin : g_cell
            if (c == NUM_CELLS - 1)
            begin : g_entry
                assign cell_in[c] = {s1_bot_reg, ram_rdata[0], ram_rdata[1]};
            end
            else
            begin : g_inner
                assign cell_in[c] = cell_out[c+1];
            end

            assign cell_pat[c] = {pattern_reg[2*NUM_CELLS+c],
                                  pattern_reg[NUM_CELLS+c],
                                  pattern_reg[c]};

            wpm_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .shift   (s1_valid_reg),
                .col_in  (cell_in[c]),
                .pat_col (cell_pat[c]),
                .col_out (cell_out[c]),
                .flags   (cell_flags[c])
            );
        end
    endgenerate

    logic    all_hit;
    logic    any_active;
    logic    interior;
    result_t q_data_in;
    result_t q_head;

    always_comb
    begin
        all_hit    = 1'b1;
        any_active = 1'b0;
        for (int i = 0; i < NUM_CELLS; i++)
        begin
            all_hit    = all_hit && cell_flags[i].hit;
            any_active = any_active || cell_flags[i].active;
        end
    end

    assign interior = (s1_x_reg >= COL_W'(2)) && (s1_y_reg >= ROW_W'(2));
    assign q_push   = s1_valid_reg && interior && all_hit && any_active;

    assign q_data_in.center_x = CENTER_W'(s1_x_reg - 1'b1);
    assign q_data_in.center_y = CENTER_W'(s1_y_reg - 1'b1);

    wpm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  (q_data_in),
        .pop_ready  (match_ready),
        .head_valid (match_valid),
        .head_data  (q_head),
        .pop        (q_pop),
        .count      (q_count)
    );

    assign center_x = q_head.center_x;
    assign center_y = q_head.center_y;

endmodule

`default_nettype wire
